[design/psp_pkg.sv]
// ----------------------------------------------------------------------------
// psp_pkg
// Shared types, constants and helpers for the packet send pacer.
// ----------------------------------------------------------------------------
package psp_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int PACKET_W    = 16;
   localparam int SOCKET_W    = 8;
   localparam int LEVEL_W     = 5;
   localparam int INTERVAL_W  = 32;

   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(1000);

   // request channel mode codes
   localparam logic MODE_SEND = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   // decision made at a request transfer, carried to the output stage
   typedef struct packed {
      logic                send_valid;
      logic                from_queue;   // packet handle comes from the FIFO RAM
      logic [PACKET_W-1:0] sent_packet;
      logic [SOCKET_W-1:0] sent_socket;
      logic                was_queued;
      logic                was_dropped;
      logic [LEVEL_W-1:0]  queue_level;
   } psp_stage_type;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

endpackage

[design/psp_if.sv]
// ----------------------------------------------------------------------------
// psp_if
// Valid/ready channel interfaces for pacer requests and responses.
// ----------------------------------------------------------------------------
interface psp_req_if import psp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                mode;
   logic [PACKET_W-1:0] packet_id;
   logic [SOCKET_W-1:0] socket_id;

   modport source (output valid, output mode, output packet_id, output socket_id,
                   input ready);
   modport sink   (input valid, input mode, input packet_id, input socket_id,
                   output ready);
endinterface

interface psp_rsp_if import psp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                send_valid;
   logic [PACKET_W-1:0] sent_packet;
   logic [SOCKET_W-1:0] sent_socket;
   logic                was_queued;
   logic                was_dropped;
   logic [LEVEL_W-1:0]  queue_level;

   modport source (output valid, output send_valid, output sent_packet,
                   output sent_socket, output was_queued, output was_dropped,
                   output queue_level, input ready);
   modport sink   (input valid, input send_valid, input sent_packet,
                   input sent_socket, input was_queued, input was_dropped,
                   input queue_level, output ready);
endinterface

[design/psp_fifo_ram.sv]
// ----------------------------------------------------------------------------
// psp_fifo_ram
// Packet handle store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module psp_fifo_ram import psp_pkg::*; (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [PTR_W-1:0]    wr_addr,
   input  logic [PACKET_W-1:0] wr_data,
   input  logic                rd_en,
   input  logic [PTR_W-1:0]    rd_addr,
   output logic [PACKET_W-1:0] rd_data
);

   logic [PACKET_W-1:0] mem_ff [QUEUE_DEPTH];
   logic [PACKET_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/psp_ctrl.sv]
// ----------------------------------------------------------------------------
// psp_ctrl
// Pacing state: idle flag, countdown, FIFO pointers, fill and last socket.
// ----------------------------------------------------------------------------
module psp_ctrl import psp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [INTERVAL_W-1:0] csr_write_data,
   input  logic                  accept,
   input  logic                  mode,
   input  logic [PACKET_W-1:0]   packet_id,
   input  logic [SOCKET_W-1:0]   socket_id,
   output psp_stage_type         stage,
   output logic                  wr_en,
   output logic [PTR_W-1:0]      wr_addr,
   output logic [PACKET_W-1:0]   wr_data,
   output logic                  rd_en,
   output logic [PTR_W-1:0]      rd_addr
);

   logic [INTERVAL_W-1:0] interval_ff;
   logic                  idle_ff, idle_in;
   logic [INTERVAL_W-1:0] countdown_ff, countdown_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic [SOCKET_W-1:0]   last_socket_ff, last_socket_in;

   logic full, immediate, push, drop, tick_act, expire, pop, go_idle;

   assign full      = (fill_ff == FILL_W'(QUEUE_DEPTH));
   assign immediate = accept && (mode == MODE_SEND) && idle_ff;
   assign push      = accept && (mode == MODE_SEND) && !idle_ff && !full;
   assign drop      = accept && (mode == MODE_SEND) && !idle_ff && full;
   assign tick_act  = accept && (mode == MODE_TICK) && !idle_ff;
   assign expire    = tick_act && (countdown_ff <= INTERVAL_W'(1));
   assign pop       = expire && (fill_ff != '0);
   assign go_idle   = expire && (fill_ff == '0);

   always_comb begin
      idle_in        = idle_ff;
      countdown_in   = countdown_ff;
      rd_ptr_in      = rd_ptr_ff;
      wr_ptr_in      = wr_ptr_ff;
      fill_in        = fill_ff;
      last_socket_in = last_socket_ff;
      if (immediate) begin
         idle_in        = 1'b0;
         countdown_in   = interval_ff;
         last_socket_in = socket_id;
      end
      if (push) begin
         wr_ptr_in = ptr_next(wr_ptr_ff);
         fill_in   = fill_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in    = ptr_next(rd_ptr_ff);
         fill_in      = fill_ff - 1'b1;
         countdown_in = interval_ff;
      end
      if (go_idle) begin
         idle_in      = 1'b1;
         countdown_in = '0;
      end
      if (tick_act && !expire) begin
         countdown_in = countdown_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff    <= INTERVAL_RESET;
         idle_ff        <= 1'b1;
         countdown_ff   <= '0;
         rd_ptr_ff      <= '0;
         wr_ptr_ff      <= '0;
         fill_ff        <= '0;
         last_socket_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            interval_ff <= csr_write_data;
         end
         idle_ff        <= idle_in;
         countdown_ff   <= countdown_in;
         rd_ptr_ff      <= rd_ptr_in;
         wr_ptr_ff      <= wr_ptr_in;
         fill_ff        <= fill_in;
         last_socket_ff <= last_socket_in;
      end
   end

   // push and pop never share a transfer, and a popped entry was written
   // at an earlier edge, so the RAM needs no bypass
   assign wr_en   = push;
   assign wr_addr = wr_ptr_ff;
   assign wr_data = packet_id;
   assign rd_en   = pop;
   assign rd_addr = rd_ptr_ff;

   always_comb begin
      stage             = '0;
      stage.send_valid  = immediate || pop;
      stage.from_queue  = pop;
      stage.sent_packet = immediate ? packet_id : '0;
      stage.sent_socket = immediate ? socket_id : (pop ? last_socket_ff : '0);
      stage.was_queued  = push;
      stage.was_dropped = drop;
      stage.queue_level = LEVEL_W'(fill_in);
   end

endmodule

[design/psp_out.sv]
// ----------------------------------------------------------------------------
// psp_out
// Two-deep result path: decision stage alongside RAM read, then output reg.
// ----------------------------------------------------------------------------
module psp_out import psp_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  psp_stage_type       stage,
   input  logic [PACKET_W-1:0] rd_data,
   output logic                in_ready,
   output logic                s1_valid,
   psp_rsp_if.source           rsp
);

   logic          s1_valid_ff;
   psp_stage_type s1_ff;
   psp_stage_type s1_out;
   logic          out_valid_ff;
   psp_stage_type out_ff;
   logic          s1_move;

   assign s1_move  = s1_valid_ff && (!out_valid_ff || rsp.ready);
   assign in_ready = !s1_valid_ff || s1_move;
   assign s1_valid = s1_valid_ff;

   // queued releases take their handle from the RAM read data
   always_comb begin
      s1_out = s1_ff;
      if (s1_ff.from_queue) begin
         s1_out.sent_packet = rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= stage;
      end
      if (s1_move) begin
         out_ff <= s1_out;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.send_valid  = out_ff.send_valid;
   assign rsp.sent_packet = out_ff.sent_packet;
   assign rsp.sent_socket = out_ff.sent_socket;
   assign rsp.was_queued  = out_ff.was_queued;
   assign rsp.was_dropped = out_ff.was_dropped;
   assign rsp.queue_level = out_ff.queue_level;

endmodule

[design/packet_send_pacer_core.sv]
// ----------------------------------------------------------------------------
// packet_send_pacer_core
// Releases packet send requests no faster than one per programmed interval.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel: each transfer is either a send request (mode send, with
//    packet_id and socket_id) or one time tick (mode tick).
//  - rsp channel: exactly one result per req transfer, in order. It says
//    whether a packet goes out now, which one, whether the request was
//    queued or dropped, and the FIFO level afterwards.
//  - csr: csr_write_enable with csr_write_data sets the interval in ticks;
//    write only while the block is empty. Takes effect at the next reload.
//  - Result path: a req transfer's decision and RAM read are registered in
//    stage 1, then the result moves into the output register that drives
//    rsp and holds there until rsp.ready.
//  - Throughput: one transfer per cycle unless rsp stalls; all pacing state
//    is updated in the transfer's cycle, so ticks can arrive back to back.
//  - Queued packets live in a QUEUE_DEPTH-entry RAM; a released queued
//    packet carries the socket of the previous release.
//  - Reset: idle, FIFO empty, interval 1000. No clearing pass.
//  - rsp stall: up to two results are buffered; req.ready then drops until
//    rsp.ready returns.
// ----------------------------------------------------------------------------
module packet_send_pacer_core import psp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [INTERVAL_W-1:0] csr_write_data,
   psp_req_if.sink               req,
   psp_rsp_if.source             rsp
);

   logic                accept;
   psp_stage_type       stage;
   logic                wr_en, rd_en;
   logic [PTR_W-1:0]    wr_addr, rd_addr;
   logic [PACKET_W-1:0] wr_data, rd_data;
   logic                in_ready;
   logic                s1_valid;

   assign accept    = req.valid && req.ready;
   assign req.ready = in_ready;

   // pacing decision and FIFO bookkeeping
   psp_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .accept           (accept),
      .mode             (req.mode),
      .packet_id        (req.packet_id),
      .socket_id        (req.socket_id),
      .stage            (stage),
      .wr_en            (wr_en),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data),
      .rd_en            (rd_en),
      .rd_addr          (rd_addr)
   );

   // waiting packet handles
   psp_fifo_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // result staging and response register
   psp_out u_out (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .stage    (stage),
      .rd_data  (rd_data),
      .in_ready (in_ready),
      .s1_valid (s1_valid),
      .rsp      (rsp)
   );

   // a release never coincides with queueing or dropping
   a_release_exclusive: assert property (@(posedge clock) disable iff (reset)
      accept && stage.send_valid |-> !stage.was_queued && !stage.was_dropped)
      else $error("release flagged as queued or dropped");

   // a drop only happens with a full FIFO
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      accept && stage.was_dropped |-> stage.queue_level == LEVEL_W'(QUEUE_DEPTH))
      else $error("drop with FIFO not full");

   // backpressure only with both result slots occupied
   a_ready_low: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> s1_valid && rsp.valid)
      else $error("req stalled with free result slot");

   // a pop reads the RAM in the cycle of the transfer
   a_pop_read: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> accept && stage.from_queue && !wr_en)
      else $error("RAM read outside a queued release");

endmodule
